FILE: sv/mrf_pkg.sv
// ----------------------------------------------------------------------------
// mrf_pkg
// Shared constants, codes, helper functions and the controller/datapath
// interface structs of the message ring FIFO.
// ----------------------------------------------------------------------------
package mrf_pkg;

	// Ring geometry.
	localparam int RING_DEPTH = 16;
	localparam int SLOT_BYTES = 64;

	// Derived widths.
	localparam int SLOT_W    = $clog2(RING_DEPTH);
	localparam int PTR_W     = $clog2(2 * RING_DEPTH);
	localparam int OFS_W     = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
	localparam int ADDR_W    = SLOT_W + OFS_W;
	localparam int MEM_DEPTH = RING_DEPTH << OFS_W;

	// Field widths that the interface fixes.
	localparam int ACT_W  = 2;
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 7;
	localparam int STS_W  = 3;

	// Result queue in front of the output port.
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PW    = $clog2(OUT_DEPTH);
	localparam int OUT_CW    = OUT_PW + 1;

	localparam logic [PTR_W-1:0] PTR_MAX   = PTR_W'(2 * RING_DEPTH - 1);
	localparam logic [LEN_W-1:0] SLOT_LEN  = LEN_W'(SLOT_BYTES);

	// Input actions.
	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH   = 2'd0,
		ACT_COMMIT = 2'd1,
		ACT_POP    = 2'd2
	} action_t;

	// Result status codes.
	typedef enum logic [STS_W-1:0] {
		ST_PUSHED     = 3'd0,
		ST_DROPPED    = 3'd1,
		ST_BYTE       = 3'd2,
		ST_EMPTY_MSG  = 3'd3,
		ST_RING_EMPTY = 3'd4,
		ST_TOO_LARGE  = 3'd5
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic push;
		logic commit;
		logic pop_empty;
		logic pop_big;
		logic pop_zero;
		logic pop_start;
		logic rd_issue;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic ring_empty;
		logic too_large;
		logic head_zero;
		logic room;
		logic last_rd;
	} sts_t;

	// Slot index of a pointer that runs modulo twice the depth.
	function automatic logic [SLOT_W-1:0] ptr_slot(input logic [PTR_W-1:0] ptr);
		logic [PTR_W-1:0] s;
		s = (ptr >= PTR_W'(RING_DEPTH)) ? ptr - PTR_W'(RING_DEPTH) : ptr;
		return s[SLOT_W-1:0];
	endfunction

	// Advance a pointer modulo twice the depth.
	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
		return (ptr == PTR_MAX) ? '0 : ptr + PTR_W'(1);
	endfunction

	// Number of committed messages in the ring.
	function automatic logic [PTR_W-1:0] ptr_fill(input logic [PTR_W-1:0] wr,
		input logic [PTR_W-1:0] rd);
		logic [PTR_W:0] d;
		if (wr >= rd) begin
			d = {1'b0, wr} - {1'b0, rd};
		end else begin
			d = {1'b0, wr} + (PTR_W+1)'(2 * RING_DEPTH) - {1'b0, rd};
		end
		return d[PTR_W-1:0];
	endfunction

endpackage

FILE: sv/mrf_ctrl.sv
// ----------------------------------------------------------------------------
// mrf_ctrl
// Controller: accepts requests, decodes them into datapath commands and
// sequences the byte stream of a pop.
// ----------------------------------------------------------------------------
module mrf_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [mrf_pkg::ACT_W-1:0]  action,
	input  mrf_pkg::sts_t              sts,
	output logic                       in_stall,
	output mrf_pkg::cmd_t              cmd
);

	typedef enum logic {
		S_IDLE,
		S_STREAM
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_stall = (state_q != S_IDLE) || !sts.room;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (action)
						mrf_pkg::ACT_PUSH: begin
							cmd.push = 1'b1;
						end
						mrf_pkg::ACT_COMMIT: begin
							cmd.commit = 1'b1;
						end
						mrf_pkg::ACT_POP: begin
							if (sts.ring_empty) begin
								cmd.pop_empty = 1'b1;
							end else if (sts.too_large) begin
								cmd.pop_big = 1'b1;
							end else if (sts.head_zero) begin
								cmd.pop_zero = 1'b1;
							end else begin
								cmd.pop_start = 1'b1;
								state_d       = S_STREAM;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_STREAM: begin
				if (sts.room) begin
					cmd.rd_issue = 1'b1;
					if (sts.last_rd) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: sv/mrf_dp.sv
// ----------------------------------------------------------------------------
// mrf_dp
// Datapath: ring pointers, pending message state, slot length table,
// message byte memory, result stage and output queue.
// ----------------------------------------------------------------------------
module mrf_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mrf_pkg::cmd_t               cmd,
	input  logic [mrf_pkg::BYTE_W-1:0]  data_byte,
	input  logic [mrf_pkg::LEN_W-1:0]   pop_capacity,
	input  logic                        out_stall,
	output mrf_pkg::sts_t               sts,
	output logic                        out_valid,
	output logic [mrf_pkg::STS_W-1:0]   status,
	output logic [mrf_pkg::BYTE_W-1:0]  data_byte_out,
	output logic [mrf_pkg::LEN_W-1:0]   message_length,
	output logic                        last
);

	// Ring state.
	logic [mrf_pkg::PTR_W-1:0]  wr_cnt_q;
	logic [mrf_pkg::PTR_W-1:0]  rd_cnt_q;
	logic [mrf_pkg::LEN_W-1:0]  pend_len_q;
	logic                       pend_drop_q;
	logic [mrf_pkg::LEN_W-1:0]  slot_len_q [mrf_pkg::RING_DEPTH];
	logic [mrf_pkg::BYTE_W-1:0] mem_q [mrf_pkg::MEM_DEPTH];

	// Stream sequencing.
	logic [mrf_pkg::SLOT_W-1:0] str_slot_q;
	logic [mrf_pkg::LEN_W-1:0]  str_len_q;
	logic [mrf_pkg::LEN_W-1:0]  str_idx_q;

	// Result stage.
	logic                       res_valid_s1;
	logic                       res_mem_s1;
	logic [mrf_pkg::STS_W-1:0]  res_status_s1;
	logic [mrf_pkg::LEN_W-1:0]  res_len_s1;
	logic                       res_last_s1;
	logic [mrf_pkg::BYTE_W-1:0] mem_rdata_s1;

	// Output queue.
	logic [mrf_pkg::STS_W-1:0]  oq_status_q [mrf_pkg::OUT_DEPTH];
	logic [mrf_pkg::BYTE_W-1:0] oq_byte_q   [mrf_pkg::OUT_DEPTH];
	logic [mrf_pkg::LEN_W-1:0]  oq_len_q    [mrf_pkg::OUT_DEPTH];
	logic                       oq_last_q   [mrf_pkg::OUT_DEPTH];
	logic [mrf_pkg::OUT_PW-1:0] oq_head_q;
	logic [mrf_pkg::OUT_PW-1:0] oq_tail_q;
	logic [mrf_pkg::OUT_CW-1:0] oq_cnt_q;

	logic [mrf_pkg::SLOT_W-1:0] wr_slot;
	logic [mrf_pkg::SLOT_W-1:0] rd_slot;
	logic [mrf_pkg::PTR_W-1:0]  fill;
	logic                       ring_full;
	logic                       pend_full;
	logic                       commit_ok;
	logic [mrf_pkg::LEN_W-1:0]  head_raw;
	logic [mrf_pkg::LEN_W-1:0]  head_len;
	logic [mrf_pkg::OUT_CW:0]   oq_used;
	logic                       mem_we;
	logic [mrf_pkg::ADDR_W-1:0] mem_waddr;
	logic [mrf_pkg::ADDR_W-1:0] mem_raddr;
	logic                       res_valid_d;
	logic [mrf_pkg::STS_W-1:0]  res_status_d;
	logic [mrf_pkg::LEN_W-1:0]  res_len_d;
	logic                       oq_push;
	logic                       oq_pop;
	logic [mrf_pkg::BYTE_W-1:0] res_byte;

	assign wr_slot   = mrf_pkg::ptr_slot(wr_cnt_q);
	assign rd_slot   = mrf_pkg::ptr_slot(rd_cnt_q);
	assign fill      = mrf_pkg::ptr_fill(wr_cnt_q, rd_cnt_q);
	assign ring_full = fill >= mrf_pkg::PTR_W'(mrf_pkg::RING_DEPTH);
	assign pend_full = pend_len_q >= mrf_pkg::SLOT_LEN;
	assign commit_ok = !pend_drop_q && !ring_full;
	assign head_raw  = slot_len_q[rd_slot];
	assign head_len  = (head_raw > mrf_pkg::SLOT_LEN) ? mrf_pkg::SLOT_LEN : head_raw;
	assign oq_used   = {1'b0, oq_cnt_q} + (mrf_pkg::OUT_CW+1)'(res_valid_s1);

	assign sts.ring_empty = (wr_cnt_q == rd_cnt_q);
	assign sts.too_large  = head_len > pop_capacity;
	assign sts.head_zero  = (head_len == '0);
	assign sts.room       = oq_used < (mrf_pkg::OUT_CW+1)'(mrf_pkg::OUT_DEPTH);
	assign sts.last_rd    = (str_idx_q + mrf_pkg::LEN_W'(1)) == str_len_q;

	assign mem_we    = cmd.push && !ring_full && !pend_full;
	assign mem_waddr = {wr_slot, pend_len_q[mrf_pkg::OFS_W-1:0]};
	assign mem_raddr = {str_slot_q, str_idx_q[mrf_pkg::OFS_W-1:0]};

	// Pointer and pending message state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_cnt_q    <= '0;
			rd_cnt_q    <= '0;
			pend_len_q  <= '0;
			pend_drop_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				if (ring_full || pend_full) begin
					pend_drop_q <= 1'b1;
				end else begin
					pend_len_q <= pend_len_q + mrf_pkg::LEN_W'(1);
				end
			end
			if (cmd.commit) begin
				pend_len_q  <= '0;
				pend_drop_q <= 1'b0;
				if (commit_ok) begin
					wr_cnt_q <= mrf_pkg::ptr_inc(wr_cnt_q);
				end
			end
			if (cmd.pop_start || cmd.pop_zero) begin
				rd_cnt_q <= mrf_pkg::ptr_inc(rd_cnt_q);
			end
		end
	end

	// Slot length table and stream registers.
	always_ff @(posedge clk) begin
		if (cmd.commit && commit_ok) begin
			slot_len_q[wr_slot] <= pend_len_q;
		end
		if (cmd.pop_start) begin
			str_slot_q <= rd_slot;
			str_len_q  <= head_len;
			str_idx_q  <= '0;
		end else if (cmd.rd_issue) begin
			str_idx_q <= str_idx_q + mrf_pkg::LEN_W'(1);
		end
	end

	// Message byte memory with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= data_byte;
		end
		if (cmd.rd_issue) begin
			mem_rdata_s1 <= mem_q[mem_raddr];
		end
	end

	always_comb begin
		res_valid_d  = cmd.commit || cmd.pop_empty || cmd.pop_big || cmd.pop_zero
			|| cmd.rd_issue;
		res_status_d = mrf_pkg::ST_BYTE;
		res_len_d    = str_len_q;
		if (cmd.commit) begin
			res_status_d = commit_ok ? mrf_pkg::ST_PUSHED : mrf_pkg::ST_DROPPED;
			res_len_d    = commit_ok ? pend_len_q : '0;
		end else if (cmd.pop_empty) begin
			res_status_d = mrf_pkg::ST_RING_EMPTY;
			res_len_d    = '0;
		end else if (cmd.pop_big) begin
			res_status_d = mrf_pkg::ST_TOO_LARGE;
			res_len_d    = head_len;
		end else if (cmd.pop_zero) begin
			res_status_d = mrf_pkg::ST_EMPTY_MSG;
			res_len_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else begin
			res_valid_s1 <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		res_status_s1 <= res_status_d;
		res_len_s1    <= res_len_d;
		res_mem_s1    <= cmd.rd_issue;
		res_last_s1   <= cmd.rd_issue ? sts.last_rd : 1'b1;
	end

	// Output queue. The controller only starts a result when there is room.
	assign oq_push  = res_valid_s1;
	assign oq_pop   = out_valid && !out_stall;
	assign res_byte = res_mem_s1 ? mem_rdata_s1 : '0;

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_status_q[oq_tail_q] <= res_status_s1;
			oq_byte_q[oq_tail_q]   <= res_byte;
			oq_len_q[oq_tail_q]    <= res_len_s1;
			oq_last_q[oq_tail_q]   <= res_last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_head_q <= '0;
			oq_tail_q <= '0;
			oq_cnt_q  <= '0;
		end else begin
			if (oq_push) begin
				oq_tail_q <= oq_tail_q + mrf_pkg::OUT_PW'(1);
			end
			if (oq_pop) begin
				oq_head_q <= oq_head_q + mrf_pkg::OUT_PW'(1);
			end
			if (oq_push && !oq_pop) begin
				oq_cnt_q <= oq_cnt_q + mrf_pkg::OUT_CW'(1);
			end else if (!oq_push && oq_pop) begin
				oq_cnt_q <= oq_cnt_q - mrf_pkg::OUT_CW'(1);
			end
		end
	end

	assign out_valid      = (oq_cnt_q != '0);
	assign status         = oq_status_q[oq_head_q];
	assign data_byte_out  = oq_byte_q[oq_head_q];
	assign message_length = oq_len_q[oq_head_q];
	assign last           = oq_last_q[oq_head_q];

`ifndef NO_ASSERTIONS
	a_oq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s1 |-> (oq_cnt_q < mrf_pkg::OUT_CW'(mrf_pkg::OUT_DEPTH)))
		else $error("output queue written while full");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= mrf_pkg::PTR_W'(mrf_pkg::RING_DEPTH))
		else $error("ring holds more messages than slots");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_len_q <= mrf_pkg::SLOT_LEN)
		else $error("pending message longer than a slot");

	a_rd_moves_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(rd_cnt_q) |-> ($past(cmd.pop_start) || $past(cmd.pop_zero)))
		else $error("read pointer moved without a pop");
`endif

endmodule

FILE: sv/message_ring_fifo.sv
// Timing: a push byte gives no result; a commit or a one-result pop passes its
// result through the result stage and the output queue; a pop streams its bytes
// one per cycle while the result queue has room, limited by the single registered
// read of the byte memory. Throughput: one request per cycle while the result
// queue has room; a streaming pop holds off new requests until its last byte.
// Reset: asynchronous active low; pointers and pending state clear, the stores keep.
// ----------------------------------------------------------------------------
// message_ring_fifo
// Single-producer single-consumer ring of fixed-size message slots. Push
// requests fill the pending message, commit publishes it, pop delivers the
// head message byte by byte.
// ----------------------------------------------------------------------------
module message_ring_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	// Request channel.
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [mrf_pkg::ACT_W-1:0]   action,
	input  logic [mrf_pkg::BYTE_W-1:0]  data_byte,
	input  logic [mrf_pkg::LEN_W-1:0]   pop_capacity,
	// Result channel.
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [mrf_pkg::STS_W-1:0]   status,
	output logic [mrf_pkg::BYTE_W-1:0]  data_byte_out,
	output logic [mrf_pkg::LEN_W-1:0]   message_length,
	output logic                        last
);

	// The controller decides what each request does from the ring status that
	// the datapath reports, and steps the byte stream of a pop. The datapath
	// owns all storage: the pointers, the pending message, the slot length
	// table, the byte memory and a small result queue in front of the output.
	mrf_pkg::cmd_t cmd;
	mrf_pkg::sts_t sts;

	mrf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// Results leave through the queue, so a waiting result never blocks a new
	// request as long as the queue has room for what that request may produce.
	mrf_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.data_byte      (data_byte),
		.pop_capacity   (pop_capacity),
		.out_stall      (out_stall),
		.sts            (sts),
		.out_valid      (out_valid),
		.status         (status),
		.data_byte_out  (data_byte_out),
		.message_length (message_length),
		.last           (last)
	);

endmodule
